// File: sv/irnn_pkg.sv
package irnn_pkg;

  localparam int MAX_SRC_HEIGHT_DEF = 256;
  localparam int MAX_SRC_WIDTH_DEF  = 256;
  localparam int PIXEL_BITS_DEF     = 16;

  localparam int ROW_W   = 9;
  localparam int COL_W   = 9;
  localparam int PIX_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DIFF_W  = 11;
  localparam int PROD_W  = 27;
  localparam int SUM_W   = 28;
  localparam int COORD_W = 16;
  localparam int SIZE_W  = 13;
  localparam int Q_SHIFT = 14;
  localparam logic [SUM_W-1:0] Q_HALF = SUM_W'(8192);

  localparam logic [CFG_IDX_W-1:0] CFG_COS_Q      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_Q      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 3'd5;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

endpackage

// File: sv/irnn_item_if.sv
interface irnn_item_if;
  import irnn_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output action, output row, output col, output pixel,
                  input ready);
  modport sink (input valid, input action, input row, input col, input pixel,
                output ready);
endinterface

// File: sv/irnn_result_if.sv
interface irnn_result_if;
  import irnn_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] value;
  logic             inside_res;

  modport source (output valid, output value, output inside_res, input ready);
  modport sink (input valid, input value, input inside_res, output ready);
endinterface

// File: sv/irnn_ram.sv
module irnn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/image_rotate_nearest_neighbor_top.sv
// Nearest-neighbor image rotation. Write transactions (action 0) store one pixel of the
// source image at row, col; positions outside the configured source size are dropped.
// Read transactions (action 1) name a pixel of the rotated output image; the block maps it
// back through the Q1.14 cosine and sine, rounds half away from zero and returns the
// nearest source pixel, or zero with inside_res clear when the point leaves the source.
// Every transaction returns exactly one result, in order. The block takes one transaction
// per clock while the result side accepts, through five register stages; a result is
// valid once its transaction reaches the fifth stage. The pixel store is one RAM of
// MAX_SRC_HEIGHT x MAX_SRC_WIDTH words with one write and one registered read port, and
// the fourth stage owns both, so a write is always visible to any later read. Store
// contents are undefined after reset; read only pixels already written. Change the
// configuration registers only while no transaction is in flight.
module image_rotate_nearest_neighbor_top #(
  parameter int MAX_SRC_HEIGHT = irnn_pkg::MAX_SRC_HEIGHT_DEF,
  parameter int MAX_SRC_WIDTH  = irnn_pkg::MAX_SRC_WIDTH_DEF,
  parameter int PIXEL_BITS     = irnn_pkg::PIXEL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [irnn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irnn_pkg::CFG_DATA_W-1:0] cfg_data,
  irnn_item_if.sink                      items,
  irnn_result_if.source                  results
);
  import irnn_pkg::*;

  localparam int RB    = $clog2(MAX_SRC_HEIGHT);
  localparam int CB    = $clog2(MAX_SRC_WIDTH);
  localparam int DEPTH = MAX_SRC_HEIGHT * MAX_SRC_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic signed [COORD_W-1:0] round_q14(input logic signed [SUM_W-1:0] x);
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] rnd;
    logic [COORD_W-1:0] r;
    mag = x[SUM_W-1] ? SUM_W'(-x) : SUM_W'(x);
    rnd = (mag + Q_HALF) >> Q_SHIFT;
    r = COORD_W'(rnd);
    round_q14 = x[SUM_W-1] ? $signed(-r) : $signed(r);
  endfunction

  logic signed [15:0] cos_q;
  logic signed [15:0] sin_q;
  logic [8:0]         src_height;
  logic [8:0]         src_width;
  logic [9:0]         out_height;
  logic [9:0]         out_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_q      <= 16'sd16384;
      sin_q      <= 16'sd0;
      src_height <= 9'd256;
      src_width  <= 9'd256;
      out_height <= 10'd256;
      out_width  <= 10'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COS_Q:      cos_q      <= $signed(cfg_data);
        CFG_SIN_Q:      sin_q      <= $signed(cfg_data);
        CFG_SRC_HEIGHT: src_height <= cfg_data[8:0];
        CFG_SRC_WIDTH:  src_width  <= cfg_data[8:0];
        CFG_OUT_HEIGHT: out_height <= cfg_data[9:0];
        CFG_OUT_WIDTH:  out_width  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0] eff_h;
  logic [SIZE_W-1:0] eff_w;

  assign eff_h = ({4'b0, src_height} > SIZE_W'(MAX_SRC_HEIGHT)) ?
                 SIZE_W'(MAX_SRC_HEIGHT) : {4'b0, src_height};
  assign eff_w = ({4'b0, src_width} > SIZE_W'(MAX_SRC_WIDTH)) ?
                 SIZE_W'(MAX_SRC_WIDTH) : {4'b0, src_width};

  logic [5:1] vld;
  logic [5:1] adv;

  always_comb begin
    adv[5] = !vld[5] || results.ready;
    for (int k = 4; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign items.ready = adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= items.valid;
      for (int k = 2; k <= 5; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: offsets from the output center
  logic                     act1;
  logic [ROW_W-1:0]         row1;
  logic [COL_W-1:0]         col1;
  logic [PIX_W-1:0]         pix1;
  logic signed [DIFF_W-1:0] di1;
  logic signed [DIFF_W-1:0] dj1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      act1 <= items.action;
      row1 <= items.row;
      col1 <= items.col;
      pix1 <= items.pixel;
      di1  <= $signed({2'b0, items.row}) - $signed({2'b0, out_height[9:1]});
      dj1  <= $signed({2'b0, items.col}) - $signed({2'b0, out_width[9:1]});
    end
  end

  // stage 2: rotation products
  logic                     act2;
  logic [ROW_W-1:0]         row2;
  logic [COL_W-1:0]         col2;
  logic [PIX_W-1:0]         pix2;
  logic signed [PROD_W-1:0] p_ic;
  logic signed [PROD_W-1:0] p_js;
  logic signed [PROD_W-1:0] p_is;
  logic signed [PROD_W-1:0] p_jc;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      act2 <= act1;
      row2 <= row1;
      col2 <= col1;
      pix2 <= pix1;
      p_ic <= PROD_W'(di1) * PROD_W'(cos_q);
      p_js <= PROD_W'(dj1) * PROD_W'(sin_q);
      p_is <= PROD_W'(di1) * PROD_W'(sin_q);
      p_jc <= PROD_W'(dj1) * PROD_W'(cos_q);
    end
  end

  // stage 3: source coordinates and bounds
  logic signed [SUM_W-1:0]   sum_i;
  logic signed [SUM_W-1:0]   sum_j;
  logic signed [COORD_W-1:0] oi;
  logic signed [COORD_W-1:0] oj;
  logic signed [COORD_W-1:0] lim_h;
  logic signed [COORD_W-1:0] lim_w;
  logic                      rd_in;
  logic                      wr_in;

  always_comb begin
    sum_i = SUM_W'(p_ic) - SUM_W'(p_js);
    sum_j = SUM_W'(p_is) + SUM_W'(p_jc);
    lim_h = $signed(COORD_W'(eff_h));
    lim_w = $signed(COORD_W'(eff_w));
    oi = round_q14(sum_i) + $signed(COORD_W'(eff_h >> 1));
    oj = round_q14(sum_j) + $signed(COORD_W'(eff_w >> 1));
    rd_in = (oi >= 0) && (oi < lim_h) && (oj >= 0) && (oj < lim_w);
    wr_in = (SIZE_W'(row2) < eff_h) && (SIZE_W'(col2) < eff_w);
  end

  logic             act3;
  logic             hit3;
  logic [PIX_W-1:0] pix3;
  logic [RB-1:0]    ri3;
  logic [CB-1:0]    ci3;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      act3 <= act2;
      pix3 <= pix2;
      if (act2 == ACT_READ) begin
        hit3 <= rd_in;
        ri3  <= RB'(oi);
        ci3  <= CB'(oj);
      end else begin
        hit3 <= wr_in;
        ri3  <= RB'(row2);
        ci3  <= CB'(col2);
      end
    end
  end

  // stage 4: store address, RAM access on advance
  logic             act4;
  logic             hit4;
  logic [PIX_W-1:0] pix4;
  logic [AW-1:0]    addr4;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      act4  <= act3;
      hit4  <= hit3;
      pix4  <= pix3;
      addr4 <= AW'(ri3) * AW'(MAX_SRC_WIDTH) + AW'(ci3);
    end
  end

  logic [PIXEL_BITS-1:0] rdata;

  irnn_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (vld[4] && adv[5] && (act4 == ACT_WRITE) && hit4),
    .waddr (addr4),
    .wdata (PIXEL_BITS'(pix4)),
    .re    (adv[5]),
    .raddr (addr4),
    .rdata (rdata)
  );

  // stage 5: result
  logic act5;
  logic hit5;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      act5 <= act4;
      hit5 <= hit4;
    end
  end

  assign results.valid      = vld[5];
  assign results.inside_res = (act5 == ACT_READ) && hit5;
  assign results.value      = results.inside_res ? PIX_W'(rdata) : '0;

endmodule
